// ===== sv/dac_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the deadlock avoidance checker.
// No dependencies.
package dac_pkg;

   localparam int DefMaxProcesses = 8;
   localparam int DefMaxResources = 4;
   localparam int DefCountBits    = 16;

   // transaction opcodes
   localparam logic [2:0] OP_SET_ID    = 3'd0;
   localparam logic [2:0] OP_LOAD_NEED = 3'd1;
   localparam logic [2:0] OP_LOAD_FREE = 3'd2;
   localparam logic [2:0] OP_REQ_ELEM  = 3'd3;
   localparam logic [2:0] OP_CHECK     = 3'd4;

   // result status codes
   localparam logic [3:0] ST_LOADED   = 4'd0;
   localparam logic [3:0] ST_REJECTED = 4'd1;
   localparam logic [3:0] ST_SAFE     = 4'd2;
   localparam logic [3:0] ST_UNSAFE   = 4'd3;
   localparam logic [3:0] ST_GRANTED  = 4'd4;
   localparam logic [3:0] ST_EXCEEDS  = 4'd5;
   localparam logic [3:0] ST_DENIED   = 4'd6;
   localparam logic [3:0] ST_UNKNOWN  = 4'd7;
   localparam logic [3:0] ST_STAGED   = 4'd8;

   // configuration register indexes
   localparam logic CSR_NUM_PROCESSES = 1'b0;
   localparam logic CSR_NUM_RESOURCES = 1'b1;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SEARCH,
      S_RQ_RD,
      S_RQ_CK,
      S_AP_RD,
      S_AP_WR,
      S_SINIT,
      S_FIT_RD,
      S_FIT_CK,
      S_ADD_RD,
      S_ADD,
      S_RB_RD,
      S_RB_WR,
      S_EMIT
   } dac_state_type;

endpackage

// ===== sv/dac_table.sv =====
`timescale 1ns / 1ps
// Allocation/need store: one write port, one registered read port.
// Depends on nothing.
module dac_table #(
   parameter int ADDR_W = 5,
   parameter int DATA_W = 32
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [2**ADDR_W];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== sv/deadlock_avoidance_checker.sv =====
`timescale 1ns / 1ps
// Banker's algorithm engine: loads, staged requests and safety test.
// Depends on dac_pkg and dac_table.
//
// Use: drive req_* with start high while busy is low; that edge takes the
// transaction. Results come out one per cycle on rsp_*, each flagged by
// rsp_strobe for a single cycle; rsp_last_result marks the final one of a
// transaction. The receiver cannot stall, so nothing here waits on it.
// Loads and non-final request elements finish in the accepting cycle, their
// result registered into the next; unknown opcodes give no result. Busy
// never rises for any of these. A check or final request element runs a
// sequencer over one shared compare/add path and a table with one read port:
// each need compared and each allocation returned takes a read state, then a
// compare or add state. A request searches the ids, checks the fit, makes a
// tentative grant, runs the safety test and rolls the grant back if unsafe.
// The one read port serialises these steps. Busy stays high throughout.
// Reset clears control state and the staged request and sets the config
// registers to 8 processes, 4 resources. Table, free counts and ids are
// undefined until loaded. Config writes on csr_* take effect at once; the
// user must make them only while idle, as the block does not enforce it.
module deadlock_avoidance_checker #(
   parameter int MAX_PROCESSES = dac_pkg::DefMaxProcesses,
   parameter int MAX_RESOURCES = dac_pkg::DefMaxResources,
   parameter int COUNT_BITS    = dac_pkg::DefCountBits
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_op,
   input  logic [2:0]  req_slot,
   input  logic [1:0]  req_resource,
   input  logic [15:0] req_process_id,
   input  logic [15:0] req_amount,
   input  logic [15:0] req_max_amount,
   input  logic        req_last,
   output logic        rsp_strobe,
   output logic [3:0]  rsp_status,
   output logic [15:0] rsp_seq_process_id,
   output logic        rsp_last_result,
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [3:0]  csr_wr_data
);
   import dac_pkg::*;

   localparam int PB  = $clog2(MAX_PROCESSES);
   localparam int RB  = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
   localparam int CB  = COUNT_BITS;
   localparam int WW  = COUNT_BITS + PB + 1;   // work counts grow with returned allocs
   localparam int AW  = PB + RB;

   // configuration
   logic [3:0] num_proc_ff;
   logic [2:0] num_res_ff;
   logic [PB:0] np;
   logic [RB:0] nr;
   logic [RB:0] nr_last;

   // sequencer state
   dac_state_type state_ff, state_in;
   logic [PB:0]   i_ff, i_in;
   logic [RB:0]   j_ff, j_in;
   logic [PB-1:0] who_ff, who_in;
   logic [PB:0]   done_ff, done_in;
   logic          progress_ff, progress_in;
   logic          is_req_ff, is_req_in;
   logic [15:0]   pid_ff, pid_in;

   logic [WW-1:0] work_ff [MAX_RESOURCES];
   logic [WW-1:0] work_in [MAX_RESOURCES];
   logic [CB-1:0] free_ff [MAX_RESOURCES];
   logic [CB-1:0] free_in [MAX_RESOURCES];
   logic [CB-1:0] req_ff  [MAX_RESOURCES];
   logic [CB-1:0] req_in  [MAX_RESOURCES];
   logic [MAX_PROCESSES-1:0] fin_ff, fin_in;
   logic [PB-1:0] order_ff [MAX_PROCESSES];
   logic [PB-1:0] order_in [MAX_PROCESSES];
   logic [15:0]   ids_ff [MAX_PROCESSES];
   logic [15:0]   ids_in [MAX_PROCESSES];

   // result register
   logic        rsp_strobe_ff, rsp_strobe_in;
   logic [3:0]  rsp_status_ff, rsp_status_in;
   logic [15:0] rsp_id_ff, rsp_id_in;
   logic        rsp_last_ff, rsp_last_in;

   // table port
   logic          mem_we;
   logic [AW-1:0] mem_waddr, mem_raddr;
   logic [2*CB-1:0] mem_wdata, mem_rdata;
   logic [CB-1:0] rd_alloc, rd_need;

   logic          slot_ok, res_ok, accept;
   logic [PB-1:0] slot_ix, ip, id_sel;
   logic [RB-1:0] res_ix, jx;
   logic [CB-1:0] amount_c, max_c;

   // clamp the counts: zero means one, above the maximum means the maximum
   always_comb begin
      if (num_proc_ff == 4'd0)                   np = (PB+1)'(1);
      else if (32'(num_proc_ff) > MAX_PROCESSES) np = (PB+1)'(MAX_PROCESSES);
      else                                       np = (PB+1)'(num_proc_ff);
      if (num_res_ff == 3'd0)                    nr = (RB+1)'(1);
      else if (32'(num_res_ff) > MAX_RESOURCES)  nr = (RB+1)'(MAX_RESOURCES);
      else                                       nr = (RB+1)'(num_res_ff);
   end

   assign nr_last  = nr - (RB+1)'(1);
   assign slot_ok  = 32'(req_slot) < 32'(np);
   assign res_ok   = 32'(req_resource) < 32'(nr);
   assign slot_ix  = PB'(req_slot);
   assign res_ix   = RB'(req_resource);
   assign amount_c = CB'(req_amount);
   assign max_c    = CB'(req_max_amount);
   assign ip       = i_ff[PB-1:0];
   assign jx       = j_ff[RB-1:0];
   assign rd_alloc = mem_rdata[2*CB-1:CB];
   assign rd_need  = mem_rdata[CB-1:0];
   assign busy     = (state_ff != S_IDLE);
   assign accept   = start && !busy;

   // request phases address the requester, the safety test walks slot i
   assign mem_raddr = (state_ff == S_RQ_RD || state_ff == S_AP_RD || state_ff == S_RB_RD)
                      ? {who_ff, jx} : {ip, jx};
   assign id_sel    = (state_ff == S_EMIT) ? order_ff[ip] : ip;

   dac_table #(
      .ADDR_W (AW),
      .DATA_W (2*CB)
   ) u_table (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   always_comb begin
      state_in      = state_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      who_in        = who_ff;
      done_in       = done_ff;
      progress_in   = progress_ff;
      is_req_in     = is_req_ff;
      pid_in        = pid_ff;
      work_in       = work_ff;
      free_in       = free_ff;
      req_in        = req_ff;
      fin_in        = fin_ff;
      order_in      = order_ff;
      ids_in        = ids_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = 16'd0;
      rsp_last_in   = 1'b1;
      mem_we        = 1'b0;
      mem_waddr     = {who_ff, jx};
      mem_wdata     = {rd_alloc + req_ff[jx], rd_need - req_ff[jx]};

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_op)
                  OP_SET_ID: begin
                     rsp_strobe_in = 1'b1;
                     rsp_status_in = slot_ok ? ST_LOADED : ST_REJECTED;
                     if (slot_ok) ids_in[slot_ix] = req_process_id;
                  end
                  OP_LOAD_NEED: begin
                     rsp_strobe_in = 1'b1;
                     if (!slot_ok || !res_ok || max_c < amount_c) begin
                        rsp_status_in = ST_REJECTED;
                     end else begin
                        rsp_status_in = ST_LOADED;
                        mem_we        = 1'b1;
                        mem_waddr     = {slot_ix, res_ix};
                        mem_wdata     = {amount_c, max_c - amount_c};
                     end
                  end
                  OP_LOAD_FREE: begin
                     rsp_strobe_in = 1'b1;
                     rsp_status_in = res_ok ? ST_LOADED : ST_REJECTED;
                     if (res_ok) free_in[res_ix] = amount_c;
                  end
                  OP_REQ_ELEM: begin
                     if (32'(req_resource) < MAX_RESOURCES) req_in[res_ix] = amount_c;
                     if (!req_last) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = ST_STAGED;
                     end else begin
                        pid_in    = req_process_id;
                        is_req_in = 1'b1;
                        i_in      = '0;
                        state_in  = S_SEARCH;
                     end
                  end
                  OP_CHECK: begin
                     is_req_in = 1'b0;
                     state_in  = S_SINIT;
                  end
                  default: ;
               endcase
            end
         end

         // first slot in use holding the requester's id
         S_SEARCH: begin
            if (i_ff == np) begin
               rsp_strobe_in = 1'b1;
               rsp_status_in = ST_UNKNOWN;
               for (int r = 0; r < MAX_RESOURCES; r++) req_in[r] = '0;
               state_in = S_IDLE;
            end else if (ids_ff[id_sel] == pid_ff) begin
               who_in   = ip;
               j_in     = '0;
               state_in = S_RQ_RD;
            end else begin
               i_in = i_ff + (PB+1)'(1);
            end
         end

         S_RQ_RD: begin
            if (j_ff == nr) begin
               j_in     = '0;
               state_in = S_AP_RD;
            end else begin
               state_in = S_RQ_CK;
            end
         end

         S_RQ_CK: begin
            if (req_ff[jx] > rd_need || req_ff[jx] > free_ff[jx]) begin
               rsp_strobe_in = 1'b1;
               rsp_status_in = ST_EXCEEDS;
               for (int r = 0; r < MAX_RESOURCES; r++) req_in[r] = '0;
               state_in = S_IDLE;
            end else begin
               j_in     = j_ff + (RB+1)'(1);
               state_in = S_RQ_RD;
            end
         end

         // tentative grant
         S_AP_RD: begin
            state_in = (j_ff == nr) ? S_SINIT : S_AP_WR;
         end

         S_AP_WR: begin
            mem_we       = 1'b1;
            free_in[jx]  = free_ff[jx] - req_ff[jx];
            j_in         = j_ff + (RB+1)'(1);
            state_in     = S_AP_RD;
         end

         S_SINIT: begin
            for (int r = 0; r < MAX_RESOURCES; r++) work_in[r] = WW'(free_ff[r]);
            fin_in      = '0;
            done_in     = '0;
            i_in        = '0;
            j_in        = '0;
            progress_in = 1'b0;
            state_in    = S_FIT_RD;
         end

         S_FIT_RD: begin
            if (i_ff == np) begin
               if (done_ff == np || !progress_ff) begin
                  // end of the safety test
                  i_in = '0;
                  j_in = '0;
                  if (is_req_ff) begin
                     if (done_ff == np) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = ST_GRANTED;
                        for (int r = 0; r < MAX_RESOURCES; r++) req_in[r] = '0;
                        state_in = S_IDLE;
                     end else begin
                        state_in = S_RB_RD;
                     end
                  end else if (done_ff == np) begin
                     state_in = S_EMIT;
                  end else begin
                     rsp_strobe_in = 1'b1;
                     rsp_status_in = ST_UNSAFE;
                     state_in      = S_IDLE;
                  end
               end else begin
                  i_in        = '0;
                  progress_in = 1'b0;
               end
            end else if (fin_ff[ip]) begin
               i_in = i_ff + (PB+1)'(1);
            end else begin
               state_in = S_FIT_CK;
            end
         end

         S_FIT_CK: begin
            if (WW'(rd_need) > work_ff[jx]) begin
               i_in     = i_ff + (PB+1)'(1);
               j_in     = '0;
               state_in = S_FIT_RD;
            end else if (j_ff == nr_last) begin
               j_in     = '0;
               state_in = S_ADD_RD;
            end else begin
               j_in     = j_ff + (RB+1)'(1);
               state_in = S_FIT_RD;
            end
         end

         S_ADD_RD: begin
            state_in = S_ADD;
         end

         // process finishes, its allocation goes back to work
         S_ADD: begin
            work_in[jx] = work_ff[jx] + WW'(rd_alloc);
            if (j_ff == nr_last) begin
               fin_in[ip]                  = 1'b1;
               order_in[done_ff[PB-1:0]]   = ip;
               done_in                     = done_ff + (PB+1)'(1);
               progress_in                 = 1'b1;
               i_in                        = i_ff + (PB+1)'(1);
               j_in                        = '0;
               state_in                    = S_FIT_RD;
            end else begin
               j_in     = j_ff + (RB+1)'(1);
               state_in = S_ADD_RD;
            end
         end

         // undo the tentative grant
         S_RB_RD: begin
            if (j_ff == nr) begin
               rsp_strobe_in = 1'b1;
               rsp_status_in = ST_DENIED;
               for (int r = 0; r < MAX_RESOURCES; r++) req_in[r] = '0;
               state_in = S_IDLE;
            end else begin
               state_in = S_RB_WR;
            end
         end

         S_RB_WR: begin
            mem_we      = 1'b1;
            mem_wdata   = {rd_alloc - req_ff[jx], rd_need + req_ff[jx]};
            free_in[jx] = free_ff[jx] + req_ff[jx];
            j_in        = j_ff + (RB+1)'(1);
            state_in    = S_RB_RD;
         end

         S_EMIT: begin
            rsp_strobe_in = 1'b1;
            rsp_status_in = ST_SAFE;
            rsp_id_in     = ids_ff[id_sel];
            rsp_last_in   = (i_ff == np - (PB+1)'(1));
            i_in          = i_ff + (PB+1)'(1);
            if (i_ff == np - (PB+1)'(1)) state_in = S_IDLE;
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         num_proc_ff   <= 4'd8;
         num_res_ff    <= 3'd4;
         rsp_strobe_ff <= 1'b0;
         fin_ff        <= '0;
         for (int r = 0; r < MAX_RESOURCES; r++) req_ff[r] <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
         fin_ff        <= fin_in;
         req_ff        <= req_in;
         if (csr_wr_en && csr_index == CSR_NUM_PROCESSES) num_proc_ff <= csr_wr_data;
         if (csr_wr_en && csr_index == CSR_NUM_RESOURCES) num_res_ff  <= csr_wr_data[2:0];
      end
   end

   always_ff @(posedge clock) begin
      i_ff          <= i_in;
      j_ff          <= j_in;
      who_ff        <= who_in;
      done_ff       <= done_in;
      progress_ff   <= progress_in;
      is_req_ff     <= is_req_in;
      pid_ff        <= pid_in;
      work_ff       <= work_in;
      free_ff       <= free_in;
      order_ff      <= order_in;
      ids_ff        <= ids_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_seq_process_id = rsp_id_ff;
   assign rsp_last_result    = rsp_last_ff;

   // only a safe sequence spreads over several results
   a_single_result: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status != ST_SAFE |-> rsp_last_result)
      else $error("non-sequence result not marked last");

   // a check always goes through the sequencer
   a_check_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_op == OP_CHECK |=> busy)
      else $error("check did not start the safety test");

   // results other than the safe sequence carry no id
   a_id_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status != ST_SAFE |-> rsp_seq_process_id == 16'd0)
      else $error("stray id on a non-sequence result");

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the deadlock avoidance checker (banker's algorithm).
// Depends on dac_pkg and the deadlock_avoidance_checker RTL.
module testbench;
   import dac_pkg::*;

   // opcodes 5..7 are not decoded by the block
   localparam logic [2:0] OP_RESERVED = 3'd5;
   localparam logic [3:0] ST_NONE     = 4'hF;
   localparam int         RandomItems = 150;

   typedef struct {
      logic [2:0]  op;
      logic [2:0]  slot;
      logic [1:0]  res;
      logic [15:0] pid;
      logic [15:0] amount;
      logic [15:0] maxa;
      logic        last;
   } cmd_type;

   typedef struct {
      logic [3:0]  status;
      logic [15:0] pid;
      logic        fin;
   } reply_type;

   // directed row: command plus, where obvious, the status of its first result
   typedef struct {
      logic [2:0]  op;
      logic [2:0]  slot;
      logic [1:0]  res;
      logic [15:0] pid;
      logic [15:0] amount;
      logic [15:0] maxa;
      logic        last;
      bit          known;
      logic [3:0]  st;
   } dir_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [2:0]  req_op = '0;
   logic [2:0]  req_slot = '0;
   logic [1:0]  req_resource = '0;
   logic [15:0] req_process_id = '0;
   logic [15:0] req_amount = '0;
   logic [15:0] req_max_amount = '0;
   logic        req_last = 1'b0;
   logic        rsp_strobe;
   logic [3:0]  rsp_status;
   logic [15:0] rsp_seq_process_id;
   logic        rsp_last_result;
   logic        csr_wr_en = 1'b0;
   logic        csr_index = 1'b0;
   logic [3:0]  csr_wr_data = '0;

   deadlock_avoidance_checker i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_op(req_op), .req_slot(req_slot), .req_resource(req_resource),
      .req_process_id(req_process_id), .req_amount(req_amount),
      .req_max_amount(req_max_amount), .req_last(req_last),
      .rsp_strobe(rsp_strobe), .rsp_status(rsp_status),
      .rsp_seq_process_id(rsp_seq_process_id), .rsp_last_result(rsp_last_result),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wr_data(csr_wr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------
   // Banker's state mirror
   // ---------------------------------------------------------------
   logic [3:0]  cfg_procs = 4'd8;
   logic [2:0]  cfg_res   = 3'd4;
   logic [15:0] held[8][4];        // allocation per slot/resource
   logic [15:0] still_needs[8][4]; // max - allocation
   logic [31:0] spare[4];          // free units
   logic [15:0] owner_id[8];
   logic [15:0] staged_req[4];
   bit          finished[8];
   int          order[8];

   reply_type   replies[$];        // results still owed by the block
   logic [3:0]  first_status;
   int          failures = 0;
   int          sent = 0;
   int          received = 0;
   int          safe_checks = 0;
   int          grants = 0;
   bit          burst = 1'b0;

   function automatic int procs_used();
      if (cfg_procs == 0) return 1;
      if (cfg_procs > 8) return 8;
      return int'(cfg_procs);
   endfunction

   function automatic int res_used();
      if (cfg_res == 0) return 1;
      if (cfg_res > 4) return 4;
      return int'(cfg_res);
   endfunction

   function automatic void add_reply(logic [3:0] st, logic [15:0] id, logic fin);
      reply_type r;
      r.status = st;
      r.pid    = id;
      r.fin    = fin;
      if (first_status == ST_NONE) first_status = st;
      replies.push_back(r);
   endfunction

   // repeated passes in slot order; a process finishes when its need fits
   function automatic bit all_can_finish();
      int np, nr, done;
      bit progress, fits;
      logic [31:0] work[4];
      np = procs_used();
      nr = res_used();
      for (int j = 0; j < 4; j++) work[j] = (j < nr) ? spare[j] : 0;
      for (int i = 0; i < 8; i++) begin
         finished[i] = 0;
         order[i] = 0;
      end
      done = 0;
      progress = 1;
      while (done < np && progress) begin
         progress = 0;
         for (int i = 0; i < np; i++) begin
            if (!finished[i]) begin
               fits = 1;
               for (int j = 0; j < nr; j++)
                  if (32'(still_needs[i][j]) > work[j]) fits = 0;
               if (fits) begin
                  for (int j = 0; j < nr; j++) work[j] += 32'(held[i][j]);
                  finished[i] = 1;
                  order[done] = i;
                  done++;
                  progress = 1;
               end
            end
         end
      end
      return done == np;
   endfunction

   function automatic void grant_or_deny(logic [15:0] id);
      int np, nr, who;
      bit found, fits;
      np = procs_used();
      nr = res_used();
      found = 0;
      who = 0;
      for (int i = 0; i < np; i++)
         if (!found && owner_id[i] == id) begin
            who = i;
            found = 1;
         end
      if (!found) begin
         add_reply(ST_UNKNOWN, '0, 1'b1);
         return;
      end
      fits = 1;
      for (int j = 0; j < nr; j++)
         if (staged_req[j] > still_needs[who][j] || 32'(staged_req[j]) > spare[j]) fits = 0;
      if (!fits) begin
         add_reply(ST_EXCEEDS, '0, 1'b1);
         return;
      end
      for (int j = 0; j < nr; j++) begin
         spare[j] -= 32'(staged_req[j]);
         held[who][j] += staged_req[j];
         still_needs[who][j] -= staged_req[j];
      end
      if (all_can_finish()) begin
         grants++;
         add_reply(ST_GRANTED, '0, 1'b1);
         return;
      end
      // roll the tentative grant back
      for (int j = 0; j < nr; j++) begin
         spare[j] += 32'(staged_req[j]);
         held[who][j] -= staged_req[j];
         still_needs[who][j] += staged_req[j];
      end
      add_reply(ST_DENIED, '0, 1'b1);
   endfunction

   function automatic void predict(cmd_type c);
      bit slot_ok, res_ok;
      int np;
      np = procs_used();
      slot_ok = int'(c.slot) < np;
      res_ok = int'(c.res) < res_used();
      first_status = ST_NONE;
      case (c.op)
         OP_SET_ID: begin
            if (!slot_ok) add_reply(ST_REJECTED, '0, 1'b1);
            else begin
               owner_id[c.slot] = c.pid;
               add_reply(ST_LOADED, '0, 1'b1);
            end
         end
         OP_LOAD_NEED: begin
            if (!slot_ok || !res_ok || c.maxa < c.amount) add_reply(ST_REJECTED, '0, 1'b1);
            else begin
               held[c.slot][c.res] = c.amount;
               still_needs[c.slot][c.res] = c.maxa - c.amount;
               add_reply(ST_LOADED, '0, 1'b1);
            end
         end
         OP_LOAD_FREE: begin
            if (!res_ok) add_reply(ST_REJECTED, '0, 1'b1);
            else begin
               spare[c.res] = 32'(c.amount);
               add_reply(ST_LOADED, '0, 1'b1);
            end
         end
         OP_REQ_ELEM: begin
            staged_req[c.res] = c.amount;
            if (!c.last) add_reply(ST_STAGED, '0, 1'b1);
            else begin
               grant_or_deny(c.pid);
               for (int j = 0; j < 4; j++) staged_req[j] = '0;
            end
         end
         OP_CHECK: begin
            if (!all_can_finish()) add_reply(ST_UNSAFE, '0, 1'b1);
            else begin
               safe_checks++;
               for (int i = 0; i < np; i++)
                  add_reply(ST_SAFE, owner_id[order[i]], i + 1 == np);
            end
         end
         default: ;  // reserved opcodes: no result, no change
      endcase
   endfunction

   // ---------------------------------------------------------------
   // Result checker: every strobe is compared with the oldest expectation
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      reply_type exp_r;
      if (!reset && rsp_strobe) begin
         received++;
         if (replies.size() == 0) begin
            $error("unexpected result: status %0d id %0h", rsp_status, rsp_seq_process_id);
            failures++;
         end else begin
            exp_r = replies.pop_front();
            if (rsp_status !== exp_r.status) begin
               $error("status: expected %0d, got %0d", exp_r.status, rsp_status);
               failures++;
            end
            if (rsp_seq_process_id !== exp_r.pid) begin
               $error("seq_process_id: expected %0h, got %0h", exp_r.pid,
                      rsp_seq_process_id);
               failures++;
            end
            if (rsp_last_result !== exp_r.fin) begin
               $error("last_result: expected %0b, got %0b", exp_r.fin, rsp_last_result);
               failures++;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------
   // Drive one transaction; it is taken at the first edge that sees busy low.
   task automatic issue(cmd_type c);
      int gap;
      start          <= 1'b1;
      req_op         <= c.op;
      req_slot       <= c.slot;
      req_resource   <= c.res;
      req_process_id <= c.pid;
      req_amount     <= c.amount;
      req_max_amount <= c.maxa;
      req_last       <= c.last;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict(c);
      sent++;
      gap = burst ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // hold off until every owed result is back and the block is idle
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (replies.size() > 0 || busy) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_cfg(logic [3:0] np, logic [3:0] nr);
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_NUM_PROCESSES;
      csr_wr_data <= np;
      @(posedge clock);
      cfg_procs = np;
      csr_index   <= CSR_NUM_RESOURCES;
      csr_wr_data <= nr;
      @(posedge clock);
      cfg_res = nr[2:0];
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [15:0] small_val();
      if ($urandom_range(0, 11) == 0) return 16'($urandom);
      return 16'($urandom_range(0, 6));
   endfunction

   function automatic cmd_type mk(logic [2:0] op, logic [2:0] slot, logic [1:0] res,
                                  logic [15:0] pid, logic [15:0] amount,
                                  logic [15:0] maxa, logic last);
      cmd_type c;
      c.op = op; c.slot = slot; c.res = res; c.pid = pid;
      c.amount = amount; c.maxa = maxa; c.last = last;
      return c;
   endfunction

   // fill every id with a random value, every table entry and free count with small, mostly solvable values
   task automatic fill_all();
      logic [15:0] a;
      for (int s = 0; s < 8; s++)
         issue(mk(OP_SET_ID, 3'(s), '0, 16'($urandom), '0, '0, 1'b0));
      for (int s = 0; s < 8; s++)
         for (int r = 0; r < 4; r++) begin
            a = 16'($urandom_range(0, 3));
            issue(mk(OP_LOAD_NEED, 3'(s), 2'(r), '0, a, a + 16'($urandom_range(0, 4)), 1'b0));
         end
      for (int r = 0; r < 4; r++)
         issue(mk(OP_LOAD_FREE, '0, 2'(r), '0, 16'($urandom_range(2, 9)), '0, 1'b0));
   endtask

   // one random transaction or a whole well-formed request sequence
   task automatic random_step();
      int pick, nr, np;
      logic [15:0] a, id;
      pick = $urandom_range(0, 99);
      np = procs_used();
      nr = res_used();
      if (pick < 14) begin
         a = small_val();
         issue(mk(OP_LOAD_NEED, 3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)), '0, a,
                  ($urandom_range(0, 9) == 0) ? 16'($urandom) : a + small_val(), 1'b0));
      end else if (pick < 22) begin
         issue(mk(OP_LOAD_FREE, '0, 2'($urandom_range(0, 3)), 16'($urandom),
                  ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'($urandom_range(0, 12)),
                  16'($urandom), 1'b0));
      end else if (pick < 27) begin
         issue(mk(OP_SET_ID, 3'($urandom_range(0, 7)), '0, 16'($urandom), '0, '0, 1'b0));
      end else if (pick < 31) begin
         issue(mk(OP_RESERVED + 3'($urandom_range(0, 2)), 3'($urandom), 2'($urandom),
                  16'($urandom), 16'($urandom), 16'($urandom), 1'($urandom)));
      end else if (pick < 50) begin
         issue(mk(OP_CHECK, 3'($urandom), 2'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), 1'($urandom)));
      end else begin
         // staged elements, then the evaluating one naming a (mostly) known requester
         for (int j = 0; j < nr; j++)
            if ($urandom_range(0, 3) != 0)
               issue(mk(OP_REQ_ELEM, 3'($urandom), 2'(j), 16'($urandom),
                        16'($urandom_range(0, 3)), 16'($urandom), 1'b0));
         id = ($urandom_range(0, 9) == 0) ? 16'($urandom) : owner_id[$urandom_range(0, np - 1)];
         issue(mk(OP_REQ_ELEM, 3'($urandom), 2'($urandom_range(0, 3)), id,
                  ($urandom_range(0, 7) == 0) ? small_val() : 16'($urandom_range(0, 3)),
                  16'($urandom), 1'b1));
      end
   endtask

   // ---------------------------------------------------------------
   // Directed table, run with 2 processes and 1 resource type
   // ---------------------------------------------------------------
   dir_row_type rows[22] = '{
      '{OP_SET_ID,    3'd0, 2'd0, 16'hFFFF, 16'd0,     16'd0,     1'b0, 1, ST_LOADED},
      '{OP_SET_ID,    3'd1, 2'd0, 16'h0000, 16'd0,     16'd0,     1'b0, 1, ST_LOADED},
      '{OP_SET_ID,    3'd2, 2'd0, 16'h1111, 16'd0,     16'd0,     1'b0, 1, ST_REJECTED},
      '{OP_LOAD_NEED, 3'd0, 2'd0, 16'd0,    16'd1,     16'd3,     1'b0, 1, ST_LOADED},
      '{OP_LOAD_NEED, 3'd1, 2'd0, 16'd0,    16'd2,     16'd6,     1'b0, 1, ST_LOADED},
      '{OP_LOAD_NEED, 3'd0, 2'd1, 16'd0,    16'd1,     16'd2,     1'b0, 1, ST_REJECTED},
      '{OP_LOAD_NEED, 3'd1, 2'd0, 16'd0,    16'd5,     16'd4,     1'b0, 1, ST_REJECTED},
      '{OP_LOAD_FREE, 3'd0, 2'd0, 16'd0,    16'd2,     16'd0,     1'b0, 1, ST_LOADED},
      '{OP_LOAD_FREE, 3'd0, 2'd1, 16'd0,    16'd9,     16'd0,     1'b0, 1, ST_REJECTED},
      '{OP_CHECK,     3'd0, 2'd0, 16'd0,    16'd0,     16'd0,     1'b0, 0, ST_NONE},
      '{OP_REQ_ELEM,  3'd0, 2'd0, 16'd0,    16'd1,     16'd0,     1'b0, 1, ST_STAGED},
      '{OP_REQ_ELEM,  3'd0, 2'd0, 16'h1234, 16'd1,     16'd0,     1'b1, 1, ST_UNKNOWN},
      '{OP_REQ_ELEM,  3'd0, 2'd0, 16'hFFFF, 16'd9,     16'd0,     1'b1, 1, ST_EXCEEDS},
      '{OP_REQ_ELEM,  3'd0, 2'd0, 16'hFFFF, 16'd1,     16'd0,     1'b1, 0, ST_NONE},
      '{OP_LOAD_FREE, 3'd0, 2'd0, 16'd0,    16'hFFFF,  16'd0,     1'b0, 1, ST_LOADED},
      '{OP_LOAD_NEED, 3'd1, 2'd0, 16'd0,    16'hFFFF,  16'hFFFF,  1'b0, 1, ST_LOADED},
      '{OP_CHECK,     3'd7, 2'd3, 16'hFFFF, 16'hFFFF,  16'hFFFF,  1'b1, 0, ST_NONE},
      '{OP_REQ_ELEM,  3'd0, 2'd3, 16'd0,    16'd7,     16'd0,     1'b0, 1, ST_STAGED},
      '{OP_REQ_ELEM,  3'd0, 2'd0, 16'h0000, 16'd0,     16'd0,     1'b1, 0, ST_NONE},
      '{OP_RESERVED,  3'd7, 2'd3, 16'hFFFF, 16'hFFFF,  16'hFFFF,  1'b1, 0, ST_NONE},
      '{OP_LOAD_NEED, 3'd0, 2'd0, 16'd0,    16'd0,     16'hFFFF,  1'b0, 1, ST_LOADED},
      '{OP_CHECK,     3'd0, 2'd0, 16'd0,    16'd0,     16'd0,     1'b0, 0, ST_NONE}
   };

   // register settings for the random phases, extremes and out-of-range values included
   logic [3:0] phase_np[7] = '{4'd1, 4'd0, 4'd15, 4'd3, 4'd8, 4'd5, 4'd2};
   logic [3:0] phase_nr[7] = '{4'd1, 4'd0, 4'd7,  4'd2, 4'd4, 4'd3, 4'd1};

   initial begin
      int rand_base, phase;
      cmd_type c;
      for (int j = 0; j < 4; j++) staged_req[j] = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_cfg(4'd2, 4'd1);
      foreach (rows[k]) begin
         c = mk(rows[k].op, rows[k].slot, rows[k].res, rows[k].pid, rows[k].amount,
                rows[k].maxa, rows[k].last);
         issue(c);
         if (rows[k].known && first_status !== rows[k].st) begin
            $error("directed row %0d: status expected %0d, predicted %0d", k, rows[k].st,
                   first_status);
            failures++;
         end
      end
      drain();

      // full size: define every table entry before anything reads it
      write_cfg(4'd8, 4'd4);
      fill_all();
      issue(mk(OP_CHECK, '0, '0, '0, '0, '0, 1'b0));
      drain();

      rand_base = sent;
      phase = 0;
      while (sent - rand_base < RandomItems) begin
         write_cfg(phase_np[phase % 7], phase_nr[phase % 7]);
         burst = (phase % 3 == 2);
         repeat (12) begin
            random_step();
            // now and then let the block run completely dry
            if ($urandom_range(0, 19) == 0) drain();
         end
         drain();
         phase++;
      end

      drain();
      repeat (50) @(posedge clock);
      if (replies.size() != 0) begin
         $error("%0d results never arrived", replies.size());
         failures++;
      end
      $display("Ran %0d transactions over %0d register settings; %0d results checked,",
               sent, phase + 2, received);
      $display("%0d safe sequences and %0d granted requests among them.", safe_checks, grants);
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // watchdog
   initial begin
      #20ms;
      $display("Test completed with failures");
      $finish;
   end

endmodule
